FILE: hdl/drfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_pkg
// Shared types and constants for the display rectangle fill sequencer.
// ----------------------------------------------------------------------------
package drfs_pkg;

  // Default sizing of the sequencer
  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int MAX_DIM_DEF     = 1024;

  // Configuration register map
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COL_OFFSET   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_OFFSET   = 2'd3;

  localparam int PANEL_DIM_W = 11;
  localparam logic [PANEL_DIM_W-1:0] PANEL_WIDTH_RST  = 11'd240;
  localparam logic [PANEL_DIM_W-1:0] PANEL_HEIGHT_RST = 11'd320;

  // Panel command bytes
  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_BUSY   = 2'd2
  } drfs_status_e;

  // One input item
  typedef struct packed {
    logic        action;   // 1 start fill, 0 tick
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] color;
  } drfs_item_t;

  // Start geometry after swap, clip and offset
  typedef struct packed {
    logic        reject;
    logic [15:0] col_first;
    logic [15:0] col_last;
    logic [15:0] row_first;
    logic [15:0] row_last;
  } drfs_geom_t;

  // One result item
  typedef struct packed {
    logic         has_byte;
    logic [7:0]   out_byte;
    logic         is_command;
    logic         release_select;
    logic         last_byte;
    drfs_status_e status;
  } drfs_result_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic pixel_phase;
  } drfs_stat_t;

endpackage

FILE: hdl/drfs_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_in_stage
// Input register: captures one item and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module drfs_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drfs_pkg::drfs_item_t in_item_i,
  input  logic               take_i,
  output logic               valid_o,
  output drfs_pkg::drfs_item_t item_o
);

  logic                 valid_d, valid_q;
  drfs_pkg::drfs_item_t item_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hdl/drfs_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_setup
// Start geometry: corner swap, panel check, clip, byte count and offsets.
// ----------------------------------------------------------------------------
module drfs_setup #(
  parameter int MAX_DIM = drfs_pkg::MAX_DIM_DEF
) (
  input  drfs_pkg::drfs_item_t                           item_i,
  input  logic [drfs_pkg::PANEL_DIM_W-1:0]               panel_width_i,
  input  logic [drfs_pkg::PANEL_DIM_W-1:0]               panel_height_i,
  input  logic [15:0]                                    col_offset_i,
  input  logic [15:0]                                    row_offset_i,
  output drfs_pkg::drfs_geom_t                           geom_o,
  output logic [$clog2(2*MAX_DIM*MAX_DIM+1)-1:0]         bytes_o
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int BL_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
  localparam int SAT_W = (DIM_W > drfs_pkg::PANEL_DIM_W) ? DIM_W : drfs_pkg::PANEL_DIM_W;

  logic [SAT_W-1:0]   pw_ext, ph_ext, max_ext;
  logic [DIM_W-1:0]   w, h;
  logic [15:0]        w16, h16;
  logic [15:0]        xs, xe, ys, ye;
  logic [15:0]        xe_c, ye_c;
  logic [DIM_W-1:0]   span_x, span_y;
  logic [2*DIM_W-1:0] area;

  // Saturate panel size at the largest supported dimension
  assign pw_ext  = SAT_W'(panel_width_i);
  assign ph_ext  = SAT_W'(panel_height_i);
  assign max_ext = SAT_W'(MAX_DIM);
  assign w       = (pw_ext > max_ext) ? DIM_W'(MAX_DIM) : DIM_W'(pw_ext);
  assign h       = (ph_ext > max_ext) ? DIM_W'(MAX_DIM) : DIM_W'(ph_ext);
  assign w16     = 16'(w);
  assign h16     = 16'(h);

  // Order the corners so that start is not past end
  always_comb begin
    if (item_i.x_end < item_i.x_start) begin
      xs = item_i.x_end;
      xe = item_i.x_start;
    end else begin
      xs = item_i.x_start;
      xe = item_i.x_end;
    end
    if (item_i.y_end < item_i.y_start) begin
      ys = item_i.y_end;
      ye = item_i.y_start;
    end else begin
      ys = item_i.y_start;
      ye = item_i.y_end;
    end
  end

  // Clip end corners to the last column and row
  assign xe_c = (xe >= w16) ? (w16 - 16'd1) : xe;
  assign ye_c = (ye >= h16) ? (h16 - 16'd1) : ye;

  // Spans fit the dimension width whenever the start is on the panel
  assign span_x = DIM_W'(xe_c - xs + 16'd1);
  assign span_y = DIM_W'(ye_c - ys + 16'd1);
  assign area   = span_x * span_y;
  assign bytes_o = BL_W'({area, 1'b0});

  assign geom_o.reject    = (xs >= w16) || (ys >= h16);
  assign geom_o.col_first = xs + col_offset_i;
  assign geom_o.col_last  = xe_c + col_offset_i;
  assign geom_o.row_first = ys + row_offset_i;
  assign geom_o.row_last  = ye_c + row_offset_i;

endmodule

FILE: hdl/drfs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_seq
// Byte sequencer: fill state, header and pixel byte generation, result register.
// ----------------------------------------------------------------------------
module drfs_seq #(
  parameter int CHUNK_BYTES = drfs_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_DIM     = drfs_pkg::MAX_DIM_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   item_valid_i,
  input  drfs_pkg::drfs_item_t                   item_i,
  input  drfs_pkg::drfs_geom_t                   geom_i,
  input  logic [$clog2(2*MAX_DIM*MAX_DIM+1)-1:0] bytes_i,
  output logic                                   take_o,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output drfs_pkg::drfs_result_t                 res_o,
  output drfs_pkg::drfs_stat_t                   stat_o
);

  localparam int BL_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
  localparam int CH_W  = $clog2(CHUNK_BYTES + 1);
  localparam int CMP_W = (BL_W > CH_W) ? BL_W : CH_W;

  // Header step codes
  localparam logic [3:0] STEP_COLSET  = 4'd0;
  localparam logic [3:0] STEP_XS_HI   = 4'd1;
  localparam logic [3:0] STEP_XS_LO   = 4'd2;
  localparam logic [3:0] STEP_XE_HI   = 4'd3;
  localparam logic [3:0] STEP_XE_LO   = 4'd4;
  localparam logic [3:0] STEP_ROWSET  = 4'd5;
  localparam logic [3:0] STEP_YS_HI   = 4'd6;
  localparam logic [3:0] STEP_YS_LO   = 4'd7;
  localparam logic [3:0] STEP_YE_HI   = 4'd8;
  localparam logic [3:0] STEP_YE_LO   = 4'd9;
  localparam logic [3:0] STEP_MEMWR_B = 4'd11;
  localparam logic [3:0] HDR_LEN      = 4'd12;

  logic              busy_d, busy_q;
  logic [3:0]        step_d, step_q;
  logic [15:0]       col_first_d, col_first_q, col_last_d, col_last_q;
  logic [15:0]       row_first_d, row_first_q, row_last_d, row_last_q;
  logic [15:0]       color_d, color_q;
  logic [BL_W-1:0]   bytes_left_d, bytes_left_q, bytes_next;
  logic [CH_W-1:0]   chunk_left_d, chunk_left_q, chunk_load, chunk_next;
  logic [CMP_W-1:0]  bl_ext, ch_ext;
  logic              res_valid_d, res_valid_q;
  drfs_pkg::drfs_result_t res_d, res_q;

  // Advance when the result register is free or drains this cycle
  assign take_o = item_valid_i && (!res_valid_q || res_ready_i);

  // Chunk size for a new select chunk
  assign bl_ext     = CMP_W'(bytes_left_q);
  assign ch_ext     = CMP_W'(CHUNK_BYTES);
  assign chunk_load = (chunk_left_q != '0) ? chunk_left_q :
                      ((bl_ext > ch_ext) ? CH_W'(CHUNK_BYTES) : CH_W'(bytes_left_q));
  assign chunk_next = chunk_load - CH_W'(1);
  assign bytes_next = bytes_left_q - BL_W'(1);

  // Next state and result for the item in front
  always_comb begin
    busy_d       = busy_q;
    step_d       = step_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    row_first_d  = row_first_q;
    row_last_d   = row_last_q;
    color_d      = color_q;
    bytes_left_d = bytes_left_q;
    chunk_left_d = chunk_left_q;
    res_d        = '0;
    res_d.status = drfs_pkg::STAT_OK;

    if (item_i.action) begin
      if (busy_q) begin
        res_d.status = drfs_pkg::STAT_BUSY;
      end else if (geom_i.reject) begin
        res_d.status = drfs_pkg::STAT_REJECT;
      end else begin
        col_first_d  = geom_i.col_first;
        col_last_d   = geom_i.col_last;
        row_first_d  = geom_i.row_first;
        row_last_d   = geom_i.row_last;
        color_d      = item_i.color;
        bytes_left_d = bytes_i;
        step_d       = STEP_COLSET;
        chunk_left_d = '0;
        busy_d       = 1'b1;
      end
    end else if (busy_q) begin
      res_d.has_byte = 1'b1;
      if (step_q < HDR_LEN) begin
        case (step_q)
          STEP_COLSET: begin
            res_d.out_byte   = drfs_pkg::CMD_COLSET;
            res_d.is_command = 1'b1;
          end
          STEP_XS_HI:  res_d.out_byte = col_first_q[15:8];
          STEP_XS_LO:  res_d.out_byte = col_first_q[7:0];
          STEP_XE_HI:  res_d.out_byte = col_last_q[15:8];
          STEP_XE_LO:  res_d.out_byte = col_last_q[7:0];
          STEP_ROWSET: begin
            res_d.out_byte   = drfs_pkg::CMD_ROWSET;
            res_d.is_command = 1'b1;
          end
          STEP_YS_HI:  res_d.out_byte = row_first_q[15:8];
          STEP_YS_LO:  res_d.out_byte = row_first_q[7:0];
          STEP_YE_HI:  res_d.out_byte = row_last_q[15:8];
          STEP_YE_LO:  res_d.out_byte = row_last_q[7:0];
          default: begin
            // both memory-write commands, each closing a select window
            res_d.out_byte       = drfs_pkg::CMD_MEMWR;
            res_d.is_command     = 1'b1;
            res_d.release_select = 1'b1;
          end
        endcase
        step_d = step_q + 4'd1;
        if ((step_q == STEP_MEMWR_B) && (bytes_left_q == '0)) begin
          res_d.last_byte = 1'b1;
          busy_d          = 1'b0;
        end
      end else begin
        // Odd count left means the low byte of the pixel is due
        res_d.out_byte = bytes_left_q[0] ? color_q[7:0] : color_q[15:8];
        bytes_left_d   = bytes_next;
        chunk_left_d   = chunk_next;
        if (chunk_next == '0) begin
          res_d.release_select = 1'b1;
        end
        if (bytes_next == '0) begin
          res_d.release_select = 1'b1;
          res_d.last_byte      = 1'b1;
          chunk_left_d         = '0;
          busy_d               = 1'b0;
        end
      end
    end
  end

  // Result register valid flag
  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // Control and fill state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      step_q       <= STEP_COLSET;
      bytes_left_q <= '0;
      chunk_left_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        busy_q       <= busy_d;
        step_q       <= step_d;
        bytes_left_q <= bytes_left_d;
        chunk_left_q <= chunk_left_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      col_first_q <= col_first_d;
      col_last_q  <= col_last_d;
      row_first_q <= row_first_d;
      row_last_q  <= row_last_d;
      color_q     <= color_d;
      res_q       <= res_d;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign res_o              = res_q;
  assign stat_o.busy        = busy_q;
  assign stat_o.pixel_phase = busy_q && (step_q >= HDR_LEN);

endmodule

FILE: hdl/display_rect_fill_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_rect_fill_sequencer
// Rectangle fill byte stream generator for a serial RGB565 panel.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one result transaction. A start item
// (tuser = 1) loads a rectangle and color; each following tick (tuser = 0)
// yields one panel byte: column-set and row-set commands with their
// coordinates, two memory-write commands, then the color bytes high byte
// first, with select released after each chunk and after the final byte.
// The block takes one item per clock cycle unless the result side stalls. An
// accepted item sits in the input register until the sequencer takes it; then
// the result register, which the sequencer state updates with, loads its
// result and presents it until the receiver takes it. Backpressure on the result
// side stalls the input only once both registers are full. Configuration
// writes are always accepted and must be made while no fill is in flight.
// ----------------------------------------------------------------------------
module display_rect_fill_sequencer #(
  parameter int CHUNK_BYTES = drfs_pkg::CHUNK_BYTES_DEF,
  parameter int MAX_DIM     = drfs_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [79:0]                     s_axis_tdata_i,  // x_start, y_start, x_end, y_end, color
  input  logic                            s_axis_tuser_i,  // action
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // out_byte
  output logic                            m_axis_tlast_o,  // last_byte
  output logic [4:0]                      m_axis_tuser_o,  // has_byte, is_command,
                                                           // release_select, status[1:0]
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [drfs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [15:0]                     cfg_data_i
);

  localparam int BL_W = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  logic [drfs_pkg::PANEL_DIM_W-1:0] panel_width_q, panel_height_q;
  logic [15:0]                      col_offset_q, row_offset_q;

  drfs_pkg::drfs_item_t   in_item, st_item;
  drfs_pkg::drfs_geom_t   geom;
  drfs_pkg::drfs_result_t res;
  drfs_pkg::drfs_stat_t   stat;
  logic                   st_valid, take;
  logic [BL_W-1:0]        bytes;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= drfs_pkg::PANEL_WIDTH_RST;
      panel_height_q <= drfs_pkg::PANEL_HEIGHT_RST;
      col_offset_q   <= '0;
      row_offset_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        drfs_pkg::CFG_PANEL_WIDTH:  panel_width_q  <= cfg_data_i[drfs_pkg::PANEL_DIM_W-1:0];
        drfs_pkg::CFG_PANEL_HEIGHT: panel_height_q <= cfg_data_i[drfs_pkg::PANEL_DIM_W-1:0];
        drfs_pkg::CFG_COL_OFFSET:   col_offset_q   <= cfg_data_i;
        drfs_pkg::CFG_ROW_OFFSET:   row_offset_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  assign in_item.action  = s_axis_tuser_i;
  assign in_item.x_start = s_axis_tdata_i[15:0];
  assign in_item.y_start = s_axis_tdata_i[31:16];
  assign in_item.x_end   = s_axis_tdata_i[47:32];
  assign in_item.y_end   = s_axis_tdata_i[63:48];
  assign in_item.color   = s_axis_tdata_i[79:64];

  drfs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (st_valid),
    .item_o     (st_item)
  );

  drfs_setup #(
    .MAX_DIM (MAX_DIM)
  ) u_setup (
    .item_i         (st_item),
    .panel_width_i  (panel_width_q),
    .panel_height_i (panel_height_q),
    .col_offset_i   (col_offset_q),
    .row_offset_i   (row_offset_q),
    .geom_o         (geom),
    .bytes_o        (bytes)
  );

  drfs_seq #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .MAX_DIM     (MAX_DIM)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (st_valid),
    .item_i       (st_item),
    .geom_i       (geom),
    .bytes_i      (bytes),
    .take_o       (take),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res),
    .stat_o       (stat)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = res.out_byte;
  assign m_axis_tlast_o = res.last_byte;
  assign m_axis_tuser_o = {res.status, res.release_select, res.is_command, res.has_byte};

  // A final byte waiting at the output means the fill has ended
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> !stat.busy)
    else $error("fill still busy while its final byte is held");

  // Input stalls only when both registers are full and the output is blocked
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output backpressure");

  // Command bytes are only the three panel commands
  a_cmd_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      ((m_axis_tdata_o == drfs_pkg::CMD_COLSET) ||
       (m_axis_tdata_o == drfs_pkg::CMD_ROWSET) ||
       (m_axis_tdata_o == drfs_pkg::CMD_MEMWR)))
    else $error("unexpected command byte");

  // Pixel phase only inside a fill
  a_pixel_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pixel_phase |-> stat.busy)
    else $error("pixel phase outside a fill");

endmodule

FILE: tb/drfs_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_stream_checker
// Watches the item, result and configuration channels of the rectangle fill
// sequencer, predicts every panel stream byte and compares it on arrival.
// ----------------------------------------------------------------------------
// Each accepted input transaction is run through a local copy of the fill
// sequencer state and yields one expected result. Results are compared
// field by field, in order, against the oldest waiting expectation.
// ----------------------------------------------------------------------------
module drfs_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item stream, as seen on the block's ports
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [79:0]                     s_axis_tdata_i,  // x_start, y_start, x_end, y_end, color
  input  logic                            s_axis_tuser_i,  // action
  // Result stream
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [7:0]                      m_axis_tdata_i,  // out_byte
  input  logic                            m_axis_tlast_i,  // last_byte
  input  logic [4:0]                      m_axis_tuser_i,  // has_byte, is_command,
                                                           // release_select, status[1:0]
  // Configuration write channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [drfs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [15:0]                     cfg_data_i,
  // Status toward the stimulus side
  output int                              fail_count_o,
  output int                              pending_o,
  output logic                            fill_busy_o,
  output int                              fills_o,
  output int                              rejects_o,
  output int                              ignored_o,
  output int                              bytes_o,
  output int                              chunk_releases_o
);
  import drfs_pkg::*;

  localparam int HDR_LEN = 12;
  localparam int CHUNK   = CHUNK_BYTES_DEF;
  localparam int MAX_DIM = MAX_DIM_DEF;

  // Local copy of the configuration
  logic [10:0]  cfg_width, cfg_height;
  logic [15:0]  cfg_col_off, cfg_row_off;

  // Local copy of the sequencer state
  logic         seq_busy;
  logic [3:0]   hdr_step;
  logic [15:0]  col_first, col_last, row_first, row_last;
  logic [15:0]  fill_color;
  logic [21:0]  bytes_left;
  logic [12:0]  chunk_left;

  drfs_result_t pending_bytes_q[$];

  int n_fail = 0;
  int n_results = 0;
  int n_fills = 0;
  int n_rejects = 0;
  int n_ignored = 0;
  int n_bytes = 0;
  int n_chunk_rel = 0;

  assign fail_count_o     = n_fail;
  assign fills_o          = n_fills;
  assign rejects_o        = n_rejects;
  assign ignored_o        = n_ignored;
  assign bytes_o          = n_bytes;
  assign chunk_releases_o = n_chunk_rel;

  // Advance the local sequencer by one item and return the byte it emits
  task automatic next_stream_byte(input logic is_start, input logic [79:0] d,
                                  output drfs_result_t r);
    int unsigned xs, ys, xe, ye, w, h, t;
    r = '0;
    r.status = STAT_OK;
    if (is_start) begin
      if (seq_busy) begin
        r.status = STAT_BUSY;
        n_ignored++;
      end else begin
        xs = d[15:0];
        ys = d[31:16];
        xe = d[47:32];
        ye = d[63:48];
        w  = (cfg_width > MAX_DIM) ? MAX_DIM : cfg_width;
        h  = (cfg_height > MAX_DIM) ? MAX_DIM : cfg_height;
        // Order the corners
        if (xe < xs) begin
          t = xs; xs = xe; xe = t;
        end
        if (ye < ys) begin
          t = ys; ys = ye; ye = t;
        end
        if (xs >= w || ys >= h) begin
          r.status = STAT_REJECT;
          n_rejects++;
        end else begin
          // Clip to the panel, then apply offsets with 16-bit wrap
          if (xe >= w) xe = w - 1;
          if (ye >= h) ye = h - 1;
          bytes_left = 22'((xe - xs + 1) * (ye - ys + 1) * 2);
          col_first  = 16'(xs + cfg_col_off);
          col_last   = 16'(xe + cfg_col_off);
          row_first  = 16'(ys + cfg_row_off);
          row_last   = 16'(ye + cfg_row_off);
          fill_color = d[79:64];
          hdr_step   = '0;
          chunk_left = '0;
          seq_busy   = 1'b1;
          n_fills++;
        end
      end
    end else if (seq_busy) begin
      r.has_byte = 1'b1;
      n_bytes++;
      if (hdr_step < HDR_LEN) begin
        // Window setup header
        case (hdr_step)
          4'd0: begin
            r.out_byte   = CMD_COLSET;
            r.is_command = 1'b1;
          end
          4'd1: r.out_byte = col_first[15:8];
          4'd2: r.out_byte = col_first[7:0];
          4'd3: r.out_byte = col_last[15:8];
          4'd4: r.out_byte = col_last[7:0];
          4'd5: begin
            r.out_byte   = CMD_ROWSET;
            r.is_command = 1'b1;
          end
          4'd6: r.out_byte = row_first[15:8];
          4'd7: r.out_byte = row_first[7:0];
          4'd8: r.out_byte = row_last[15:8];
          4'd9: r.out_byte = row_last[7:0];
          default: begin
            r.out_byte       = CMD_MEMWR;
            r.is_command     = 1'b1;
            r.release_select = 1'b1;
          end
        endcase
        hdr_step++;
        if (hdr_step == HDR_LEN && bytes_left == 0) begin
          r.last_byte = 1'b1;
          seq_busy    = 1'b0;
        end
      end else begin
        // Color bytes, high byte first, select dropped per chunk
        if (chunk_left == 0)
          chunk_left = (bytes_left > CHUNK) ? 13'(CHUNK) : 13'(bytes_left);
        r.out_byte = bytes_left[0] ? fill_color[7:0] : fill_color[15:8];
        bytes_left--;
        chunk_left--;
        if (chunk_left == 0) r.release_select = 1'b1;
        if (bytes_left == 0) begin
          r.release_select = 1'b1;
          r.last_byte      = 1'b1;
          chunk_left       = '0;
          seq_busy         = 1'b0;
        end else if (chunk_left == 0) begin
          n_chunk_rel++;
        end
      end
    end
  endtask

  // Track configuration, compare results, predict new items
  always @(posedge clk_i or negedge rst_ni) begin
    drfs_result_t want, got;
    if (!rst_ni) begin
      cfg_width   = PANEL_WIDTH_RST;
      cfg_height  = PANEL_HEIGHT_RST;
      cfg_col_off = '0;
      cfg_row_off = '0;
      seq_busy    = 1'b0;
      hdr_step    = '0;
      col_first   = '0;
      col_last    = '0;
      row_first   = '0;
      row_last    = '0;
      fill_color  = '0;
      bytes_left  = '0;
      chunk_left  = '0;
      pending_bytes_q.delete();
      pending_o   <= 0;
      fill_busy_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_PANEL_WIDTH:  cfg_width   = cfg_data_i[10:0];
          CFG_PANEL_HEIGHT: cfg_height  = cfg_data_i[10:0];
          CFG_COL_OFFSET:   cfg_col_off = cfg_data_i;
          CFG_ROW_OFFSET:   cfg_row_off = cfg_data_i;
          default: ;
        endcase
      end

      // Results are compared before this edge's item is predicted
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.has_byte       = m_axis_tuser_i[0];
        got.out_byte       = m_axis_tdata_i;
        got.is_command     = m_axis_tuser_i[1];
        got.release_select = m_axis_tuser_i[2];
        got.last_byte      = m_axis_tlast_i;
        got.status         = drfs_status_e'(m_axis_tuser_i[4:3]);
        if (pending_bytes_q.size() == 0) begin
          if (n_fail < 10)
            $display("[%0t] result %0d arrived with nothing expected: byte=%02h user=%02b",
                     $realtime, n_results, got.out_byte, m_axis_tuser_i);
          n_fail++;
        end else begin
          want = pending_bytes_q.pop_front();
          if (got !== want) begin
            if (n_fail < 10)
              $display({"[%0t] result %0d mismatch: expected has=%0b byte=%02h cmd=%0b ",
                        "rel=%0b last=%0b status=%0d, got has=%0b byte=%02h cmd=%0b ",
                        "rel=%0b last=%0b status=%0d"},
                       $realtime, n_results,
                       want.has_byte, want.out_byte, want.is_command,
                       want.release_select, want.last_byte, want.status,
                       got.has_byte, got.out_byte, got.is_command,
                       got.release_select, got.last_byte, got.status);
            n_fail++;
          end
        end
        n_results++;
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        next_stream_byte(s_axis_tuser_i, s_axis_tdata_i, want);
        pending_bytes_q.push_back(want);
      end

      pending_o   <= pending_bytes_q.size();
      fill_busy_o <= seq_busy;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the display rectangle fill sequencer.
// ----------------------------------------------------------------------------
// Drives rectangle starts and byte ticks with random gaps and result-side
// stalls over a series of panel sizes and offsets: directed corner cases,
// then mostly complete fills with random content mixed with broken
// sequences and off-panel noise. A separate checker predicts and compares
// every result transaction.
// ----------------------------------------------------------------------------
module testbench;
  import drfs_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int MAX_GAP      = 14;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [79:0]           s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;

  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic [4:0]            m_axis_tuser;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [15:0]           cfg_data  = '0;

  int   fail_count, pending, fills, rejects, ignored, bytes_seen, chunk_rel;
  logic fill_busy;

  int          n_items   = 0;
  int          n_setups  = 1;
  int          cycle_cnt = 0;
  bit          gapless   = 1'b0;
  int          hold_req  = 0;
  int          hold_done = 0;
  int unsigned cur_w     = 240;
  int unsigned cur_h     = 320;

  display_rect_fill_sequencer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  drfs_stream_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tuser_i   (s_axis_tuser),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tlast_i   (m_axis_tlast),
    .m_axis_tuser_i   (m_axis_tuser),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_addr_i       (cfg_addr),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .fill_busy_o      (fill_busy),
    .fills_o          (fills),
    .rejects_o        (rejects),
    .ignored_o        (ignored),
    .bytes_o          (bytes_seen),
    .chunk_releases_o (chunk_rel)
  );

  // Clock
  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [79:0] rand80();
    return {16'($urandom), $urandom(), $urandom()};
  endfunction

  function automatic logic [79:0] pack_start(logic [15:0] xs, logic [15:0] ys,
                                             logic [15:0] xe, logic [15:0] ye,
                                             logic [15:0] color);
    return {color, ye, xe, ys, xs};
  endfunction

  // Small rectangle near the current panel, sometimes off it or clipped
  function automatic logic [79:0] pick_rect();
    int unsigned xs, ys, xe, ye;
    int mode;
    xs = (cur_w > 0) ? $urandom_range(0, cur_w - 1) : $urandom_range(0, 3);
    ys = (cur_h > 0) ? $urandom_range(0, cur_h - 1) : $urandom_range(0, 3);
    xe = xs + $urandom_range(0, 3);
    ye = ys + $urandom_range(0, 3);
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        xs = cur_w + $urandom_range(0, 200);
        xe = xs + $urandom_range(0, 3);
      end
      1: begin
        ys = cur_h + $urandom_range(0, 200);
        ye = ys + $urandom_range(0, 3);
      end
      2: begin
        xs = (cur_w > 3) ? cur_w - $urandom_range(1, 3) : 0;
        xe = 16'hFFFF;
      end
      3: begin
        ys = (cur_h > 3) ? cur_h - $urandom_range(1, 3) : 0;
        ye = 16'hFFFF;
      end
      default: ;
    endcase
    // Reverse corners at random
    if ($urandom_range(0, 1))
      return pack_start(16'(xe), 16'(ys), 16'(xs), 16'(ye), 16'($urandom));
    else if ($urandom_range(0, 1))
      return pack_start(16'(xs), 16'(ye), 16'(xe), 16'(ys), 16'($urandom));
    else
      return pack_start(16'(xs), 16'(ys), 16'(xe), 16'(ye), 16'($urandom));
  endfunction

  // Random start kept off the panel so that noise never begins a long fill
  function automatic logic [79:0] noise_start();
    logic [79:0] d;
    d = rand80();
    if ($urandom_range(0, 1)) begin
      d[26] = 1'b1;
      d[58] = 1'b1;
    end else begin
      d[10] = 1'b1;
      d[42] = 1'b1;
    end
    return d;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic act, input logic [79:0] d);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  // Start a fill and tick until it completes; optionally break it up
  task automatic run_fill(input logic [79:0] start_d, input bit allow_noise);
    send_item(1'b1, start_d);
    do begin
      send_item(1'b0, rand80());
      if (allow_noise && $urandom_range(0, 39) == 0)
        send_item(1'b1, pick_rect());
      if (allow_noise && $urandom_range(0, 59) == 0)
        break;
    end while (fill_busy);
  endtask

  // Stop offering, hold until every predicted result has come, then settle
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Drain, then write all four registers
  task automatic configure(input logic [10:0] w, input logic [10:0] h,
                           input logic [15:0] col_off, input logic [15:0] row_off);
    wait_for_drain();
    write_reg(CFG_PANEL_WIDTH,  {5'($urandom), w});
    write_reg(CFG_PANEL_HEIGHT, {5'($urandom), h});
    write_reg(CFG_COL_OFFSET,   col_off);
    write_reg(CFG_ROW_OFFSET,   row_off);
    cfg_valid <= 1'b0;
    cur_w = (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
    cur_h = (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
    n_setups++;
  endtask

  // Mostly complete fills, the rest noise
  task automatic random_phase(input int quota);
    int stop_at;
    stop_at = n_items + quota;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 9) < 8)
        run_fill(pick_rect(), 1'b1);
      else if ($urandom_range(0, 1))
        send_item(1'b1, noise_start());
      else
        send_item(1'b0, rand80());
    end
  endtask

  // Result side: random stalls, one long hold on request
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_done != hold_req) begin
        stall = LONG_HOLD;
        hold_done++;
      end else begin
        stall = gapless ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases at the reset panel of 240 x 320
    send_item(1'b0, rand80());
    send_item(1'b1, pack_start(16'd240, 16'd0, 16'd240, 16'd5, 16'hF800));
    send_item(1'b1, pack_start(16'd0, 16'd320, 16'd3, 16'd400, 16'h07E0));
    send_item(1'b1, pack_start(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(1'b1, pack_start(16'd1, 16'd0, 16'd0, 16'd0, 16'hA55A));
    repeat (5) send_item(1'b0, rand80());
    send_item(1'b1, pack_start(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000));
    do send_item(1'b0, rand80()); while (fill_busy);

    random_phase(120);

    // Single-pixel panel with wrapping offsets; receiver holds off for long
    configure(11'd1, 11'd1, 16'hFFFF, 16'hFFFF);
    gapless = 1'b1;
    hold_req++;
    random_phase(150);
    gapless = 1'b0;

    // Largest panel with random offsets
    configure(11'd1024, 11'd1024, 16'($urandom), 16'($urandom));
    random_phase(150);

    // Sizes above the maximum saturate
    configure(11'd2047, 11'd1500, 16'hFFF0, 16'h0010);
    gapless = 1'b1;
    random_phase(150);
    gapless = 1'b0;

    // Zero width, then zero height: every start is rejected
    configure(11'd0, 11'd50, 16'h0000, 16'h0000);
    random_phase(50);
    configure(11'd100, 11'd0, 16'h8000, 16'h7FFF);
    random_phase(30);

    configure(11'd64, 11'd48, 16'($urandom), 16'($urandom));
    random_phase(170);

    configure(11'd240, 11'd320, 16'h0000, 16'h0000);
    random_phase(150);

    s_axis_tvalid <= 1'b0;
    wait_for_drain();

    $display("covered %0d items over %0d panel setups: %0d fills, %0d rejected, %0d ignored",
             n_items, n_setups, fills, rejects, ignored);
    $display("%0d stream bytes emitted, %0d mid-fill chunk releases, %0d failures",
             bytes_seen, chunk_rel, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
